### rtl/ico_directory_largest_entry_parser_top_macros.svh
// Assertion macros shared by the icon directory parser modules.
`ifndef ICO_DIRECTORY_LARGEST_ENTRY_PARSER_TOP_MACROS_SVH
`define ICO_DIRECTORY_LARGEST_ENTRY_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ICODP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("icodp: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ICODP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("icodp: next-cycle check failed");

`endif

### rtl/icodp_pkg.sv
// Shared types and constants of the icon directory parser.
`timescale 1ns / 1ps

package icodp_pkg;

    localparam int unsigned TDATA_W = 104;
    localparam int unsigned TUSER_W = 3;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_TOO_SHORT     = 3'd1,
        ST_BAD_HEADER    = 3'd2,
        ST_BAD_COUNT     = 3'd3,
        ST_OUT_OF_BOUNDS = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] best_index;
        logic [8:0]  best_width;
        logic [8:0]  best_height;
        logic [31:0] image_offset;
        logic [31:0] image_length;
    } t_result;

endpackage

### rtl/icodp_in_reg.sv
// Input register that holds one accepted byte until the parser takes it.
`timescale 1ns / 1ps

module icodp_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  icodp_pkg::t_in_item i_item,
    output logic                o_valid,
    output icodp_pkg::t_in_item o_item,
    input  logic                i_take
);
    import icodp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/icodp_parse.sv
// Header and directory parsing state with the final status decision.
`timescale 1ns / 1ps
`include "ico_directory_largest_entry_parser_top_macros.svh"

module icodp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  icodp_pkg::t_in_item i_item,
    input  logic                i_out_free,
    output logic                o_take,
    output logic                o_res_valid,
    output icodp_pkg::t_result  o_result
);
    import icodp_pkg::*;

    localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] IDX_HEADER_END = 32'd4;
    localparam logic [31:0] IDX_HEADER_ONE = 32'd2;
    localparam logic [31:0] IDX_COUNT_LO   = 32'd4;
    localparam logic [31:0] IDX_COUNT_HI   = 32'd5;
    localparam logic [31:0] HEADER_BYTES   = 32'd6;
    localparam logic [8:0]  FULL_SIDE      = 9'd256;
    localparam logic [3:0]  POS_WIDTH      = 4'd0;
    localparam logic [3:0]  POS_HEIGHT     = 4'd1;
    localparam logic [3:0]  POS_LAST       = 4'd15;

    logic [31:0] r_bytes_seen, n_bytes_seen;
    logic        r_header_good, n_header_good;
    logic [15:0] r_entry_total, n_entry_total;
    logic [15:0] r_entry_cursor, n_entry_cursor;
    logic [3:0]  r_byte_in_entry, n_byte_in_entry;
    logic [8:0]  r_current_width, n_current_width;
    logic        r_current_wins, n_current_wins;
    logic [16:0] r_best_pixels, n_best_pixels;
    logic [15:0] r_best_entry, n_best_entry;
    logic [8:0]  r_best_width, n_best_width;
    logic [8:0]  r_best_height, n_best_height;
    logic [31:0] r_best_offset, n_best_offset;
    logic [31:0] r_best_length, n_best_length;

    logic [7:0]  b;
    logic [8:0]  side;
    logic [17:0] pix;
    logic [4:0]  shift;
    logic [32:0] bound_sum;
    t_status     status;
    logic        final_byte;

    assign b          = i_item.byte_value;
    assign o_take     = i_valid && (!i_item.last_byte || i_out_free);
    assign final_byte = o_take && i_item.last_byte;
    assign side       = (b == 8'd0) ? FULL_SIDE : {1'b0, b};
    assign pix        = {9'd0, r_current_width} * {9'd0, side};
    assign shift      = {r_byte_in_entry[1:0], 3'b000};

    always_comb begin
        n_bytes_seen    = r_bytes_seen;
        n_header_good   = r_header_good;
        n_entry_total   = r_entry_total;
        n_entry_cursor  = r_entry_cursor;
        n_byte_in_entry = r_byte_in_entry;
        n_current_width = r_current_width;
        n_current_wins  = r_current_wins;
        n_best_pixels   = r_best_pixels;
        n_best_entry    = r_best_entry;
        n_best_width    = r_best_width;
        n_best_height   = r_best_height;
        n_best_offset   = r_best_offset;
        n_best_length   = r_best_length;

        if (r_bytes_seen < IDX_HEADER_END) begin
            if (b != ((r_bytes_seen == IDX_HEADER_ONE) ? 8'd1 : 8'd0)) begin
                n_header_good = 1'b0;
            end
        end else if (r_bytes_seen == IDX_COUNT_LO) begin
            n_entry_total[7:0] = b;
        end else if (r_bytes_seen == IDX_COUNT_HI) begin
            n_entry_total[15:8] = b;
        end else if (r_entry_cursor < r_entry_total) begin
            case (r_byte_in_entry) inside
                POS_WIDTH: begin
                    n_current_width = side;
                    n_current_wins  = 1'b0;
                end
                POS_HEIGHT: begin
                    if (pix > {1'b0, r_best_pixels}) begin
                        n_best_pixels  = pix[16:0];
                        n_best_entry   = r_entry_cursor;
                        n_best_width   = r_current_width;
                        n_best_height  = side;
                        n_current_wins = 1'b1;
                    end
                end
                [4'd8:4'd11]: begin
                    if (r_current_wins) begin
                        n_best_length[shift +: 8] = b;
                    end
                end
                [4'd12:4'd15]: begin
                    if (r_current_wins) begin
                        n_best_offset[shift +: 8] = b;
                    end
                end
                default: begin
                end
            endcase
            if (r_byte_in_entry == POS_LAST) begin
                n_byte_in_entry = 4'd0;
                n_entry_cursor  = r_entry_cursor + 16'd1;
            end else begin
                n_byte_in_entry = r_byte_in_entry + 4'd1;
            end
        end

        if (r_bytes_seen != COUNT_MAX) begin
            n_bytes_seen = r_bytes_seen + 32'd1;
        end
    end

    assign bound_sum = {1'b0, n_best_offset} + {1'b0, n_best_length};

    always_comb begin
        if (n_bytes_seen < HEADER_BYTES) begin
            status = ST_TOO_SHORT;
        end else if (!n_header_good) begin
            status = ST_BAD_HEADER;
        end else if (n_entry_total == 16'd0 || n_entry_cursor < n_entry_total) begin
            status = ST_BAD_COUNT;
        end else if (bound_sum > {1'b0, n_bytes_seen}) begin
            status = ST_OUT_OF_BOUNDS;
        end else begin
            status = ST_OK;
        end

        o_result.status = status;
        if (status == ST_OK) begin
            o_result.best_index   = n_best_entry;
            o_result.best_width   = n_best_width;
            o_result.best_height  = n_best_height;
            o_result.image_offset = n_best_offset;
            o_result.image_length = n_best_length;
        end else begin
            o_result.best_index   = 16'd0;
            o_result.best_width   = 9'd0;
            o_result.best_height  = 9'd0;
            o_result.image_offset = 32'd0;
            o_result.image_length = 32'd0;
        end
    end

    assign o_res_valid = final_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || final_byte) begin
            r_bytes_seen    <= 32'd0;
            r_header_good   <= 1'b1;
            r_entry_total   <= 16'd0;
            r_entry_cursor  <= 16'd0;
            r_byte_in_entry <= 4'd0;
            r_current_width <= 9'd0;
            r_current_wins  <= 1'b0;
            r_best_pixels   <= 17'd0;
            r_best_entry    <= 16'd0;
            r_best_width    <= 9'd0;
            r_best_height   <= 9'd0;
            r_best_offset   <= 32'd0;
            r_best_length   <= 32'd0;
        end else if (o_take) begin
            r_bytes_seen    <= n_bytes_seen;
            r_header_good   <= n_header_good;
            r_entry_total   <= n_entry_total;
            r_entry_cursor  <= n_entry_cursor;
            r_byte_in_entry <= n_byte_in_entry;
            r_current_width <= n_current_width;
            r_current_wins  <= n_current_wins;
            r_best_pixels   <= n_best_pixels;
            r_best_entry    <= n_best_entry;
            r_best_width    <= n_best_width;
            r_best_height   <= n_best_height;
            r_best_offset   <= n_best_offset;
            r_best_length   <= n_best_length;
        end
    end

    // A result leaves only when the output stage can hold it, and it restarts the file state.
    `ICODP_ASSERT_NOW(a_result_needs_room, i_clk, i_rst_n, o_res_valid, i_out_free)
    `ICODP_ASSERT_NEXT(a_restart_after_final, i_clk, i_rst_n, final_byte,
        r_bytes_seen == 32'd0 && r_entry_cursor == 16'd0 && r_header_good)
    `ICODP_ASSERT_NOW(a_error_zero_fields, i_clk, i_rst_n,
        o_res_valid && o_result.status != ST_OK,
        o_result.image_offset == 32'd0 && o_result.image_length == 32'd0 &&
        o_result.best_index == 16'd0)
    `ICODP_ASSERT_NOW(a_header_drop_early, i_clk, i_rst_n, $fell(r_header_good),
        $past(r_bytes_seen) < IDX_HEADER_END)

endmodule

### rtl/icodp_out_reg.sv
// Output register that holds one status transaction until the receiver takes it.
`timescale 1ns / 1ps

module icodp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  icodp_pkg::t_result i_result,
    output logic               o_free,
    output logic               o_valid,
    output icodp_pkg::t_result o_result,
    input  logic               i_ready
);
    import icodp_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/ico_directory_largest_entry_parser_top.sv
// Icon directory parser: picks the largest directory entry of an ICO byte stream.
//
// The slave stream carries the file one byte per transaction, with tlast on the
// final byte. The master stream carries one status transaction per file, sent
// after the final byte: tuser holds the status code and tdata the chosen entry
// (index, width, height, offset, length), all zero unless the status is ok.
// Throughput is one byte per cycle but for a final byte that waits for room in
// the output register. Each byte passes an input register and combinational
// parsing logic that writes the status into the output register; m_axis_tvalid
// rises once that logic has loaded the status of the final byte.
// The output register holds one status transaction. While it waits for the
// receiver, non-final bytes keep flowing; a following final byte waits in the
// input register until the output register frees, and the slave side stalls.
// Synchronous reset clears both registers and restarts the parser at the first
// byte of a new file. The parser also restarts by itself after each final byte.
`timescale 1ns / 1ps

module ico_directory_largest_entry_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Bits 7:0 byte_value.
    input  logic [7:0]                    s_axis_tdata,
    // last_byte.
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // From bit 0: best_index 16, best_width 9, best_height 9, image_offset 32,
    // image_length 32, zero fill 6.
    output logic [icodp_pkg::TDATA_W-1:0] m_axis_tdata,
    // Bits 2:0 status.
    output logic [icodp_pkg::TUSER_W-1:0] m_axis_tuser
);
    import icodp_pkg::*;

    t_in_item in_item, held_item;
    t_result  parse_result, out_result;
    logic     held_valid, take, res_valid, out_free;

    assign in_item.byte_value = s_axis_tdata;
    assign in_item.last_byte  = s_axis_tlast;

    icodp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (take)
    );

    icodp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_item      (held_item),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_result    (parse_result)
    );

    icodp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (res_valid),
        .i_result (parse_result),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .o_result (out_result),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_result.image_length, out_result.image_offset,
                           out_result.best_height, out_result.best_width,
                           out_result.best_index};
    assign m_axis_tuser = out_result.status;

endmodule
